/* design/assert_macros.svh */
// assertion macros for the rtl files; the top level includes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_PROP(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// boolean that must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

`endif

/* design/rtmn_pkg.sv */
// types and constants of the triangular mesh node generator
`default_nettype none
package rtmn_pkg;

   localparam int COORD_W   = 32;
   localparam int IDX_W     = 14;
   localparam int CSR_IDX_W = 2;

   localparam logic [COORD_W-1:0] LEFT_X_RESET   = 32'h0000_0000;
   localparam logic [COORD_W-1:0] RIGHT_X_RESET  = 32'h0001_0000;
   localparam logic [COORD_W-1:0] BOTTOM_Y_RESET = 32'h0000_0000;
   localparam logic [COORD_W-1:0] TOP_Y_RESET    = 32'h0001_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEFT_X,
      CSR_RIGHT_X,
      CSR_BOTTOM_Y,
      CSR_TOP_Y
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_SQUARE,
      MODE_WIDE,
      MODE_TALL
   } mesh_mode_type;

   // per-node data carried alongside the divider
   typedef struct packed {
      logic               ok;
      logic               lat_x;
      logic               lat_y;
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
   } node_side_type;

endpackage
`default_nettype wire

/* design/rtmn_ifs.sv */
// channel interfaces: node request, node response and register write
`default_nettype none
interface rtmn_req_if;
   logic                        valid;
   logic                        ready;
   logic [rtmn_pkg::IDX_W-1:0]  node_index;
   modport source (output valid, output node_index, input ready);
   modport sink (input valid, input node_index, output ready);
endinterface

interface rtmn_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rtmn_pkg::COORD_W-1:0]  node_x;
   logic [rtmn_pkg::COORD_W-1:0]  node_y;
   logic                          node_valid;
   logic [rtmn_pkg::IDX_W-1:0]    node_total;
   logic                          steps_clamped;
   modport source (output valid, output node_x, output node_y, output node_valid,
                   output node_total, output steps_clamped, input ready);
   modport sink (input valid, input node_x, input node_y, input node_valid,
                 input node_total, input steps_clamped, output ready);
endinterface

interface rtmn_csr_if;
   logic                             valid;
   logic                             ready;
   logic [rtmn_pkg::CSR_IDX_W-1:0]   index;
   logic [rtmn_pkg::COORD_W-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* design/rect_triangular_mesh_node.sv */
// top level: rectangle registers, lattice step search and node pipeline
`default_nettype none
`include "assert_macros.svh"
// Returns one node of the initial triangular-lattice mesh of a rectangle per request
// word. After reset and after every register write a setup sequencer works out the
// mesh shape: a wide (tall) rectangle's column (row) count comes from a binary search
// whose probes square q*sht as three products of its 23- and 22-bit halves (default);
// during setup req_ch.ready is low. Once set up, the node pipeline takes one word per
// cycle while the skid stage is empty; it registers decode, product, numerator and one
// divider stage per numerator bit ($clog2(MAX_STEPS+1)+34 bits) before the output. A
// one-word skid stage behind the output register lets one more word through while a
// response waits; after that the whole pipeline holds until the response is taken.
module rect_triangular_mesh_node #(
   parameter int MAX_STEPS = 4096
) (
   input  wire         clock,
   input  wire         reset,
   rtmn_req_if.sink    req_ch,
   rtmn_rsp_if.source  rsp_ch,
   rtmn_csr_if.sink    csr_ch
);
   import rtmn_pkg::*;

   localparam int CW  = $clog2(MAX_STEPS + 1);
   localparam int TW  = CW + 2;
   localparam int XW  = (TW > IDX_W ? TW : IDX_W) + 1;
   localparam int PW  = CW + COORD_W;
   localparam int NW  = PW + 2;
   localparam int RW  = CW + 1;
   localparam int AW  = CW + COORD_W;
   localparam int HW  = (AW + 1) / 2;
   localparam int LW  = AW - HW;
   localparam int ACW = 2 * AW;

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_LSQ, S_MULA, S_SQ0, S_SQ1, S_SQ2, S_CMP, S_ITER, S_FIN
   } setup_state_type;

   typedef struct packed {
      logic          v;
      node_side_type side;
      logic [CW-1:0] j;
   } dec_stage_type;

   typedef struct packed {
      logic          v;
      node_side_type side;
      logic [PW-1:0] prod;
   } mul_stage_type;

   typedef struct packed {
      logic          v;
      node_side_type side;
      logic [NW-1:0] num;
      logic [RW-1:0] rem;
   } div_stage_type;

   // rectangle registers
   logic [COORD_W-1:0] l_ff, r_ff, b_ff, t_ff;

   // setup results and search state
   setup_state_type    setup_state_ff;
   mesh_mode_type      mode_ff;
   logic [COORD_W-1:0] lng_ff, sht_ff, half_ff;
   logic [2*COORD_W-1:0] lsq_ff;
   logic [CW-1:0]      q_ff, lo_ff, hi_ff, m_ff, d_ff;
   logic [RW-1:0]      dd_ff;
   logic [TW-1:0]      total_ff;
   logic               clamp_ff, first_ff;
   logic [AW-1:0]      a_ff;
   logic [ACW-1:0]     acc_ff;

   logic busy;
   logic en;
   assign busy = (setup_state_ff != S_IDLE);

   // shape of the current rectangle
   logic signed [COORD_W:0] dx, dy;
   mesh_mode_type           ld_mode;
   logic [COORD_W-1:0]      ld_lng, ld_sht;
   logic [COORD_W:0]        ld_half;
   always_comb begin
      dx = $signed({r_ff[COORD_W-1], r_ff}) - $signed({l_ff[COORD_W-1], l_ff});
      dy = $signed({t_ff[COORD_W-1], t_ff}) - $signed({b_ff[COORD_W-1], b_ff});
      if (dx <= 0 || dy <= 0) begin
         ld_mode = MODE_NONE;
      end else if (dx == dy) begin
         ld_mode = MODE_SQUARE;
      end else if (dx > dy) begin
         ld_mode = MODE_WIDE;
      end else begin
         ld_mode = MODE_TALL;
      end
      if (ld_mode == MODE_TALL) begin
         ld_lng = dy[COORD_W-1:0];
         ld_sht = dx[COORD_W-1:0];
      end else begin
         ld_lng = dx[COORD_W-1:0];
         ld_sht = dy[COORD_W-1:0];
      end
      ld_half = ({1'b0, ld_sht} + (COORD_W+1)'(1)) >> 1;
   end

   // probe test: 3*(q*sht)^2 >= (2*lng)^2
   logic [LW-1:0]    a_hi;
   logic [HW-1:0]    a_lo;
   logic [ACW+1:0]   cov_lhs, cov_rhs;
   logic             cov;
   always_comb begin
      a_hi    = a_ff[AW-1:HW];
      a_lo    = a_ff[HW-1:0];
      cov_lhs = {acc_ff, 1'b0} + (ACW+2)'(acc_ff);
      cov_rhs = (ACW+2)'({lsq_ff, 2'b00});
      cov     = (cov_lhs >= cov_rhs);
   end

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         l_ff           <= LEFT_X_RESET;
         r_ff           <= RIGHT_X_RESET;
         b_ff           <= BOTTOM_Y_RESET;
         t_ff           <= TOP_Y_RESET;
         setup_state_ff <= S_LOAD;
         mode_ff        <= MODE_NONE;
         first_ff       <= 1'b0;
      end else if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_LEFT_X:   l_ff <= csr_ch.data;
            CSR_RIGHT_X:  r_ff <= csr_ch.data;
            CSR_BOTTOM_Y: b_ff <= csr_ch.data;
            CSR_TOP_Y:    t_ff <= csr_ch.data;
         endcase
         setup_state_ff <= S_LOAD;
      end else begin
         unique case (setup_state_ff)
            S_IDLE: begin
            end
            S_LOAD: begin
               mode_ff <= ld_mode;
               lng_ff  <= ld_lng;
               sht_ff  <= ld_sht;
               half_ff <= ld_half[COORD_W-1:0];
               if (ld_mode == MODE_WIDE || ld_mode == MODE_TALL) begin
                  setup_state_ff <= S_LSQ;
               end else begin
                  m_ff           <= CW'(2);
                  clamp_ff       <= 1'b0;
                  setup_state_ff <= S_FIN;
               end
            end
            S_LSQ: begin
               lsq_ff         <= lng_ff * lng_ff;
               q_ff           <= CW'(MAX_STEPS - 1);
               first_ff       <= 1'b1;
               setup_state_ff <= S_MULA;
            end
            S_MULA: begin
               a_ff           <= AW'(q_ff) * AW'(sht_ff);
               setup_state_ff <= S_SQ0;
            end
            S_SQ0: begin
               acc_ff         <= ACW'(a_lo) * ACW'(a_lo);
               setup_state_ff <= S_SQ1;
            end
            S_SQ1: begin
               acc_ff         <= acc_ff + ((ACW'(a_lo) * ACW'(a_hi)) << (HW + 1));
               setup_state_ff <= S_SQ2;
            end
            S_SQ2: begin
               acc_ff         <= acc_ff + ((ACW'(a_hi) * ACW'(a_hi)) << (2 * HW));
               setup_state_ff <= S_CMP;
            end
            S_CMP: begin
               first_ff <= 1'b0;
               if (first_ff) begin
                  if (!cov) begin
                     m_ff           <= CW'(MAX_STEPS);
                     clamp_ff       <= 1'b1;
                     setup_state_ff <= S_FIN;
                  end else begin
                     lo_ff          <= CW'(1);
                     hi_ff          <= CW'(MAX_STEPS - 1);
                     setup_state_ff <= S_ITER;
                  end
               end else begin
                  if (cov) begin
                     hi_ff <= q_ff;
                  end else begin
                     lo_ff <= q_ff + CW'(1);
                  end
                  setup_state_ff <= S_ITER;
               end
            end
            S_ITER: begin
               if (lo_ff < hi_ff) begin
                  q_ff           <= lo_ff + ((hi_ff - lo_ff) >> 1);
                  setup_state_ff <= S_MULA;
               end else begin
                  m_ff           <= lo_ff + CW'(1);
                  clamp_ff       <= 1'b0;
                  setup_state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               d_ff  <= m_ff - CW'(1);
               dd_ff <= {m_ff - CW'(1), 1'b0};
               unique case (mode_ff)
                  MODE_NONE: begin
                     total_ff <= '0;
                     clamp_ff <= 1'b0;
                  end
                  MODE_SQUARE: total_ff <= TW'(4);
                  MODE_WIDE, MODE_TALL:
                     total_ff <= {m_ff, 1'b0} + TW'(m_ff >> 1);
               endcase
               setup_state_ff <= S_IDLE;
            end
            default: setup_state_ff <= S_IDLE;
         endcase
      end
   end

   // node decode: which lattice coordinate and its fixed partner
   logic [IDX_W-1:0] idx;
   logic [XW-1:0]    idx_x, m_x, m2_x, tot_x, jx;
   dec_stage_type    dec_in, dec_ff;
   always_comb begin
      idx   = req_ch.node_index;
      idx_x = XW'(idx);
      m_x   = XW'(m_ff);
      m2_x  = m_x << 1;
      tot_x = XW'(total_ff);
      jx    = '0;
      dec_in = '0;
      dec_in.v       = req_ch.valid && req_ch.ready;
      dec_in.side.ok = (idx_x < tot_x);
      unique case (mode_ff)
         MODE_NONE: begin
         end
         MODE_SQUARE: begin
            dec_in.side.px = (idx == IDX_W'(1) || idx == IDX_W'(2)) ? r_ff : l_ff;
            dec_in.side.py = (idx >= IDX_W'(2)) ? t_ff : b_ff;
         end
         MODE_WIDE: begin
            dec_in.side.px    = l_ff;
            dec_in.side.lat_x = 1'b1;
            if (idx_x < m_x) begin
               jx             = idx_x;
               dec_in.side.py = idx[0] ? b_ff + half_ff : b_ff;
            end else if (idx_x < m2_x) begin
               jx             = idx_x - m_x;
               dec_in.side.py = t_ff;
            end else begin
               jx             = ((idx_x - m2_x) << 1) + XW'(1);
               dec_in.side.py = b_ff;
            end
         end
         MODE_TALL: begin
            dec_in.side.py    = b_ff;
            dec_in.side.lat_y = 1'b1;
            if (idx_x < m2_x) begin
               jx = idx_x >> 1;
               if (idx[0]) begin
                  dec_in.side.px = r_ff;
               end else begin
                  dec_in.side.px = jx[0] ? l_ff + half_ff : l_ff;
               end
            end else begin
               jx             = ((idx_x - m2_x) << 1) + XW'(1);
               dec_in.side.px = l_ff;
            end
         end
      endcase
      dec_in.j = jx[CW-1:0];
      if (!dec_in.side.ok) begin
         dec_in.side = '0;
      end
   end

   // j * len, then numerator 2*j*len + d of the rounded division by 2d
   mul_stage_type mul_in, mul_ff;
   div_stage_type div_ff [NW+1];
   div_stage_type div_in [NW+1];
   logic [RW:0]   tr    [NW+1];
   logic          ge    [NW+1];
   always_comb begin
      mul_in.v    = dec_ff.v;
      mul_in.side = dec_ff.side;
      mul_in.prod = PW'(dec_ff.j) * PW'(lng_ff);

      div_in[0].v    = mul_ff.v;
      div_in[0].side = mul_ff.side;
      div_in[0].num  = NW'({mul_ff.prod, 1'b0}) + NW'(d_ff);
      div_in[0].rem  = '0;
      tr[0] = '0;
      ge[0] = 1'b0;
      // one quotient bit per stage
      for (int k = 1; k <= NW; k++) begin
         tr[k] = {div_ff[k-1].rem, div_ff[k-1].num[NW-1]};
         ge[k] = (tr[k] >= {1'b0, dd_ff});
         div_in[k].v    = div_ff[k-1].v;
         div_in[k].side = div_ff[k-1].side;
         div_in[k].num  = {div_ff[k-1].num[NW-2:0], ge[k]};
         div_in[k].rem  = ge[k] ? RW'(tr[k] - {1'b0, dd_ff}) : tr[k][RW-1:0];
      end
   end

   // final coordinate add
   node_side_type      fin_side;
   logic               fin_v;
   logic [COORD_W-1:0] fin_q, fin_x, fin_y;
   always_comb begin
      fin_v    = div_ff[NW].v;
      fin_side = div_ff[NW].side;
      fin_q    = div_ff[NW].num[COORD_W-1:0];
      fin_x    = fin_side.lat_x ? fin_side.px + fin_q : fin_side.px;
      fin_y    = fin_side.lat_y ? fin_side.py + fin_q : fin_side.py;
   end

   // output register with skid stage
   logic               out_v_ff, skid_v_ff;
   logic [COORD_W-1:0] out_x_ff, out_y_ff, skid_x_ff, skid_y_ff;
   logic               out_ok_ff, skid_ok_ff;
   logic               take, push;

   assign en    = !skid_v_ff;
   assign take  = out_v_ff && rsp_ch.ready;
   assign push  = en && fin_v;
   assign req_ch.ready = en && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff.v <= 1'b0;
         mul_ff.v <= 1'b0;
         for (int k = 0; k <= NW; k++) begin
            div_ff[k].v <= 1'b0;
         end
      end else if (en) begin
         dec_ff <= dec_in;
         mul_ff <= mul_in;
         for (int k = 0; k <= NW; k++) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (take) begin
            out_x_ff  <= skid_x_ff;
            out_y_ff  <= skid_y_ff;
            out_ok_ff <= skid_ok_ff;
            skid_v_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_v_ff || take) begin
            out_x_ff  <= fin_x;
            out_y_ff  <= fin_y;
            out_ok_ff <= fin_side.ok;
            out_v_ff  <= 1'b1;
         end else begin
            skid_x_ff  <= fin_x;
            skid_y_ff  <= fin_y;
            skid_ok_ff <= fin_side.ok;
            skid_v_ff  <= 1'b1;
         end
      end else if (take) begin
         out_v_ff <= 1'b0;
      end
   end

   logic [XW-1:0] total_x;
   assign total_x              = XW'(total_ff);
   assign rsp_ch.valid         = out_v_ff;
   assign rsp_ch.node_x        = out_x_ff;
   assign rsp_ch.node_y        = out_y_ff;
   assign rsp_ch.node_valid    = out_ok_ff;
   assign rsp_ch.node_total    = total_x[IDX_W-1:0];
   assign rsp_ch.steps_clamped = clamp_ff;

   `ASSERT_ALWAYS(a_no_accept_in_setup, !(busy && req_ch.ready), "word accepted during setup")
   `ASSERT_PROP(a_write_restarts_setup, csr_ch.valid && csr_ch.ready |=> setup_state_ff == S_LOAD, "register write did not restart setup")
   `ASSERT_PROP(a_search_bounds, setup_state_ff == S_ITER |-> lo_ff <= hi_ff, "step search bounds crossed")
   `ASSERT_PROP(a_skid_only_on_stall, $rose(skid_v_ff) |-> $past(rsp_ch.valid && !rsp_ch.ready), "skid filled without a stalled response")

endmodule
`default_nettype wire
